[hw/rtl/hss_pkg.sv]
// Shared constants, types and microcode table of the hover setpoint shaper.
`default_nettype none
package hss_pkg;

  localparam int FRAC_BITS    = 12;
  localparam int MIN_HEIGHT_Q = 819;
  localparam int MAX_HEIGHT_Q = 8192;

  localparam longint ONE_Q       = longint'(1) << FRAC_BITS;
  localparam int     SNAP_Q      = int'((99 * ONE_Q) / 100);
  localparam longint P_QUIET_MAX = (ONE_Q * ONE_Q - 1) / 100;
  localparam int     DRIFT_MIN   = int'(ONE_Q / 20 + 1);

  // floor(p*75 / (1000 << FRAC_BITS)) = floor(floor(3p >> HT_SHIFT) / 5)
  localparam int HT_SHIFT   = FRAC_BITS + 3;
  localparam int DIV5_BIAS  = 100000;
  localparam int DIV5_BIASQ = DIV5_BIAS / 5;
  localparam int RECIP5     = 209716;
  localparam int RECIP_SH   = 20;

  localparam int IN_W   = 88;
  localparam int OUT_W  = 56;
  localparam int CIDX_W = 3;
  localparam int CDAT_W = 32;

  localparam logic [1:0] OP_FLY     = 2'd0;
  localparam logic [1:0] OP_TAKEOFF = 2'd1;
  localparam logic [1:0] OP_LAND    = 2'd2;

  localparam logic [CIDX_W-1:0] REG_MAX_FWD  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_ACCEL    = 3'd1;
  localparam logic [CIDX_W-1:0] REG_DECEL    = 3'd2;
  localparam logic [CIDX_W-1:0] REG_HOVER    = 3'd3;
  localparam logic [CIDX_W-1:0] REG_LIMIT    = 3'd4;
  localparam logic [CIDX_W-1:0] REG_DRIFT    = 3'd5;
  localparam logic [CIDX_W-1:0] REG_CLIMB_GN = 3'd6;
  localparam logic [CIDX_W-1:0] REG_TURN_GN  = 3'd7;

  localparam int UPC_W = 3;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t STEP_DECODE = 3'd0;
  localparam upc_t STEP_PROD   = 3'd1;
  localparam upc_t STEP_YAW    = 3'd2;
  localparam upc_t STEP_HEIGHT = 3'd3;
  localparam upc_t STEP_SKIP   = 3'd4;

  typedef enum logic [1:0] {
    MS_NONE  = 2'd0,
    MS_CLIMB = 2'd1,
    MS_TURN  = 2'd2,
    MS_RECIP = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     decode;
    mul_sel_t mul;
    logic     ld_p;
    logic     ld_yaw;
    logic     ld_hs;
    logic     jmp;
    upc_t     tgt;
    logic     done;
  } ucw_t;

  function automatic ucw_t urom(input upc_t a);
    ucw_t w;
    w = '{decode: 1'b0, mul: MS_NONE, ld_p: 1'b0, ld_yaw: 1'b0, ld_hs: 1'b0,
          jmp: 1'b0, tgt: STEP_DECODE, done: 1'b1};
    unique case (a)
      STEP_DECODE: begin
        w.decode = 1'b1; w.mul = MS_CLIMB; w.jmp = 1'b1; w.tgt = STEP_SKIP;
        w.done = 1'b0;
      end
      STEP_PROD: begin
        w.ld_p = 1'b1; w.mul = MS_TURN; w.done = 1'b0;
      end
      STEP_YAW: begin
        w.ld_yaw = 1'b1; w.mul = MS_RECIP; w.done = 1'b0;
      end
      STEP_HEIGHT: begin
        w.ld_hs = 1'b1; w.done = 1'b1;
      end
      default: begin
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/hover_setpoint_shaper.sv]
// Top level of the hover setpoint shaper: ports, registers and datapath.
// One command item in, one setpoint item out. A short microprogram runs each item
// through one shared 19x19 multiplier: a fly item that issues a setpoint passes the
// accept cycle and then four steps (decode with the climb product, yaw product,
// divide-by-five product, height/speed update) before the next item can be taken;
// take-off, land, forced landing, idle and unknown items pass through accept, decode
// and finish. The input is accepted while an earlier result still waits on the
// output register; the last step stalls only if that register is still full.
`default_nettype none
module hover_setpoint_shaper #(
  parameter int HEIGHT_MIN = hss_pkg::MIN_HEIGHT_Q,
  parameter int HEIGHT_MAX = hss_pkg::MAX_HEIGHT_Q
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // forward_cmd[15:0] climb_cmd[31:16] turn_cmd[47:32]
  // time_ms[79:48] battery_low[80] charger_on[81], zero pad [87:82]
  input  wire logic [hss_pkg::IN_W-1:0]    in_tdata,
  // opcode[1:0]
  input  wire logic [1:0]                  in_tuser,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // flying[0] setpoint_valid[1] land_request[2] takeoff_request[3]
  // forward_speed[19:4] height_target[34:20] turn_rate[50:35], zero pad [55:51]
  output logic [hss_pkg::OUT_W-1:0]        out_tdata,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [hss_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [hss_pkg::CDAT_W-1:0]  cfg_data
);
  import hss_pkg::*;

  // configuration
  logic [14:0] max_fwd_r, accel_r, decel_r, hover_r, drift_r, cgain_r;
  logic [15:0] tgain_r;
  logic [31:0] limit_r;

  // flight state
  logic               in_flight_r, in_flight_nxt;
  logic [14:0]        height_r, height_nxt;
  logic signed [15:0] last_fwd_r, last_fwd_nxt;
  logic [31:0]        start_r, start_nxt;
  logic               tmr_on_r, tmr_on_nxt;

  // item registers
  logic [1:0]         op_r;
  logic signed [15:0] fwd_r, climb_r, turn_r;
  logic [31:0]        time_r;
  logic               batt_r, chg_r;

  // datapath
  logic signed [37:0] prod_r;
  logic signed [31:0] p_r;
  logic signed [15:0] yaw_r;
  logic               valid_r, land_r, to_r;
  logic               valid_nxt, land_nxt, to_nxt;

  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;

  logic  busy, hold, run, in_acc, sp;
  ucw_t  cw;

  assign in_tready  = !busy;
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign hold       = cw.done && out_valid_r && !out_tready;
  assign run        = busy && !hold;

  hss_useq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc),
    .take_jump (!sp),
    .hold      (hold),
    .busy      (busy),
    .cw        (cw)
  );

  // decode
  logic [31:0] t0, elapsed;
  logic        forced;
  assign t0      = tmr_on_r ? start_r : time_r;
  assign elapsed = time_r - t0;
  assign forced  = (in_flight_r && (elapsed >= limit_r)) || batt_r;
  assign sp      = (op_r == OP_FLY) && !forced && in_flight_r && !chg_r;

  // shared multiplier
  logic signed [33:0] p3;
  logic signed [18:0] q_s, u_s;
  logic signed [18:0] mul_a, mul_b;
  assign p3  = {{2{p_r[31]}}, p_r} + {p_r[31], p_r, 1'b0};
  assign q_s = {p3[32], p3[32:HT_SHIFT]};
  assign u_s = q_s + 19'(DIV5_BIAS);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cw.mul)
      MS_CLIMB: begin
        mul_a = {{3{climb_r[15]}}, climb_r};
        mul_b = $signed({4'b0, cgain_r});
      end
      MS_TURN: begin
        mul_a = {{3{turn_r[15]}}, turn_r};
        mul_b = $signed({3'b0, tgain_r});
      end
      MS_RECIP: begin
        mul_a = $signed({1'b0, u_s[17:0]});
        mul_b = 19'(RECIP5);
      end
      MS_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // yaw saturation
  logic signed [25:0] yfull;
  logic signed [15:0] ysat;
  assign yfull = prod_r[37:FRAC_BITS];
  always_comb begin
    if (yfull > 26'sd32767)       ysat = 16'sd32767;
    else if (yfull < -26'sd32768) ysat = -16'sd32768;
    else                          ysat = yfull[15:0];
  end

  // height
  logic [15:0]        quo;
  logic signed [16:0] delta;
  logic signed [18:0] h0, hd, hd_abs;
  logic [31:0]        p_abs;
  logic               drift;
  logic signed [19:0] h1;
  logic [14:0]        hnew;
  assign quo    = prod_r[RECIP_SH+15:RECIP_SH];
  assign delta  = $signed({1'b0, quo}) - 17'(DIV5_BIASQ);
  assign h0     = $signed({4'b0, height_r}) + {{2{delta[16]}}, delta};
  assign hd     = h0 - $signed({4'b0, hover_r});
  assign hd_abs = hd[18] ? -hd : hd;
  assign p_abs  = p_r[31] ? 32'(-p_r) : 32'(p_r);
  assign drift  = (p_abs <= 32'(P_QUIET_MAX)) && (hd_abs >= 19'(DRIFT_MIN));
  always_comb begin
    if (!drift)       h1 = {h0[18], h0};
    else if (hd > 0)  h1 = {h0[18], h0} - $signed({5'b0, drift_r});
    else              h1 = {h0[18], h0} + $signed({5'b0, drift_r});
    if (h1 < $signed(20'(HEIGHT_MIN)))      hnew = 15'(HEIGHT_MIN);
    else if (h1 > $signed(20'(HEIGHT_MAX))) hnew = 15'(HEIGHT_MAX);
    else                                    hnew = h1[14:0];
  end

  // forward speed
  logic signed [15:0] spd0, spd;
  logic signed [16:0] sdiff;
  assign spd0  = (fwd_r > $signed(16'(SNAP_Q))) ? $signed({1'b0, max_fwd_r}) : fwd_r;
  assign sdiff = {spd0[15], spd0} - {last_fwd_r[15], last_fwd_r};
  always_comb begin
    if (sdiff > $signed({2'b0, accel_r}))
      spd = last_fwd_r + $signed({1'b0, accel_r});
    else if (sdiff < -$signed({2'b0, decel_r}))
      spd = last_fwd_r - $signed({1'b0, decel_r});
    else
      spd = spd0;
  end

  always_comb begin
    in_flight_nxt = in_flight_r;
    height_nxt    = height_r;
    last_fwd_nxt  = last_fwd_r;
    start_nxt     = start_r;
    tmr_on_nxt    = tmr_on_r;
    valid_nxt     = valid_r;
    land_nxt      = land_r;
    to_nxt        = to_r;
    if (run && cw.decode) begin
      valid_nxt = sp;
      land_nxt  = 1'b0;
      to_nxt    = 1'b0;
      unique case (op_r)
        OP_TAKEOFF: begin
          in_flight_nxt = 1'b1;
          height_nxt    = hover_r;
          to_nxt        = 1'b1;
        end
        OP_LAND: begin
          in_flight_nxt = 1'b0;
          height_nxt    = '0;
          land_nxt      = 1'b1;
        end
        OP_FLY: begin
          start_nxt  = t0;
          tmr_on_nxt = 1'b1;
          if (forced) begin
            in_flight_nxt = 1'b0;
            height_nxt    = '0;
            land_nxt      = 1'b1;
          end
        end
        default: begin
          valid_nxt = 1'b0;
        end
      endcase
    end
    if (run && cw.ld_hs) begin
      height_nxt   = hnew;
      last_fwd_nxt = spd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_fwd_r   <= 15'd4096;
      accel_r     <= 15'd307;
      decel_r     <= 15'd3072;
      hover_r     <= 15'd2458;
      limit_r     <= 32'd60000;
      drift_r     <= 15'd41;
      cgain_r     <= 15'd4096;
      tgain_r     <= 16'd4096;
      in_flight_r <= 1'b0;
      height_r    <= '0;
      last_fwd_r  <= '0;
      start_r     <= '0;
      tmr_on_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MAX_FWD:  max_fwd_r <= cfg_data[14:0];
          REG_ACCEL:    accel_r   <= cfg_data[14:0];
          REG_DECEL:    decel_r   <= cfg_data[14:0];
          REG_HOVER:    hover_r   <= cfg_data[14:0];
          REG_LIMIT:    limit_r   <= cfg_data;
          REG_DRIFT:    drift_r   <= cfg_data[14:0];
          REG_CLIMB_GN: cgain_r   <= cfg_data[14:0];
          REG_TURN_GN:  tgain_r   <= cfg_data[15:0];
          default: ;
        endcase
      end
      in_flight_r <= in_flight_nxt;
      height_r    <= height_nxt;
      last_fwd_r  <= last_fwd_nxt;
      start_r     <= start_nxt;
      tmr_on_r    <= tmr_on_nxt;
      if (run && cw.done) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= in_tuser;
      fwd_r   <= in_tdata[15:0];
      climb_r <= in_tdata[31:16];
      turn_r  <= in_tdata[47:32];
      time_r  <= in_tdata[79:48];
      batt_r  <= in_tdata[80];
      chg_r   <= in_tdata[81];
    end
    valid_r <= valid_nxt;
    land_r  <= land_nxt;
    to_r    <= to_nxt;
    if (run && cw.mul != MS_NONE) prod_r <= mul_a * mul_b;
    if (run && cw.ld_p)           p_r    <= prod_r[31:0];
    if (run && cw.ld_yaw)         yaw_r  <= ysat;
    if (run && cw.done) begin
      out_data_r <= {5'b0,
                     valid_r ? yaw_r : 16'sd0,
                     height_nxt,
                     valid_r ? last_fwd_nxt : 16'sd0,
                     to_r, land_r, valid_r, in_flight_nxt};
    end
  end

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[2] && out_tdata[3]))
    else $error("land and take-off requested together");

  a_sp_flying: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[0] && !out_tdata[2])
    else $error("setpoint issued while not flying");

  a_sp_height: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |->
      out_tdata[34:20] >= 15'(HEIGHT_MIN) && out_tdata[34:20] <= 15'(HEIGHT_MAX))
    else $error("setpoint height outside limits");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("item taken while sequencer still busy");

endmodule
`default_nettype wire

[hw/rtl/hss_useq.sv]
// Microcode sequencer: step counter, control store and conditional jump.
`default_nettype none
module hss_useq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          take_jump,
  input  wire logic          hold,
  output logic               busy,
  output hss_pkg::ucw_t      cw
);
  import hss_pkg::*;

  upc_t upc_r, upc_nxt;
  logic busy_r, busy_nxt;

  assign cw   = urom(upc_r);
  assign busy = busy_r;

  always_comb begin
    upc_nxt  = upc_r;
    busy_nxt = busy_r;
    priority if (start) begin
      busy_nxt = 1'b1;
      upc_nxt  = STEP_DECODE;
    end else if (busy_r && !hold) begin
      if (cw.done) begin
        busy_nxt = 1'b0;
      end else if (cw.jmp && take_jump) begin
        upc_nxt = cw.tgt;
      end else begin
        upc_nxt = upc_r + upc_t'(1);
      end
    end else begin
      upc_nxt  = upc_r;
      busy_nxt = busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r  <= STEP_DECODE;
      busy_r <= 1'b0;
    end else begin
      upc_r  <= upc_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule
`default_nettype wire
